// ----- src/espd_pkg.sv -----
// ----------------------------------------------------------------------------
// espd_pkg
// Types and constants shared by the encoder speed PID drive unit.
// ----------------------------------------------------------------------------
`default_nettype none

package espd_pkg;

	localparam int MS_W     = 16;
	localparam int SPEED_W  = 26;
	localparam int POS_W    = 48;
	localparam int SUM_W    = 40;
	localparam int ERR_W    = 27;
	localparam int DERIV_W  = 28;
	localparam int GAIN_W   = 16;
	localparam int DUTY_W   = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int MULB_W   = 40;
	localparam int PROD_W   = GAIN_W + MULB_W;
	localparam int ACC_W    = 58;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING = 3'd4;

	localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = 16'sd256;
	localparam logic [DUTY_W-1:0] DUTY_CEILING_RESET  = 16'd255;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SPD,
		ST_ERR,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_MAG,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic spd;
		logic err;
		logic mul0;
		logic mul1;
		logic mul2;
		logic acc;
		logic mag;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ----- src/espd_ctrl.sv -----
// ----------------------------------------------------------------------------
// espd_ctrl
// Sequencer for one control tick: divide, error update, three multiplies,
// magnitude and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module espd_ctrl #(
	parameter int DIV_STEPS = 26
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire espd_pkg::status_t status,
	output espd_pkg::cmd_t        cmd,
	output logic                  in_stall
);

	localparam int CNT_W = $clog2(DIV_STEPS + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

	espd_pkg::state_t state_q, state_n;
	logic [CNT_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= espd_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == espd_pkg::ST_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			espd_pkg::ST_IDLE: if (in_valid) state_n = espd_pkg::ST_DIV;
			espd_pkg::ST_DIV:  if (step_q == LAST_STEP) state_n = espd_pkg::ST_SPD;
			espd_pkg::ST_SPD:  state_n = espd_pkg::ST_ERR;
			espd_pkg::ST_ERR:  state_n = espd_pkg::ST_MUL0;
			espd_pkg::ST_MUL0: state_n = espd_pkg::ST_MUL1;
			espd_pkg::ST_MUL1: state_n = espd_pkg::ST_MUL2;
			espd_pkg::ST_MUL2: state_n = espd_pkg::ST_ACC;
			espd_pkg::ST_ACC:  state_n = espd_pkg::ST_MAG;
			espd_pkg::ST_MAG:  state_n = espd_pkg::ST_FIN;
			espd_pkg::ST_FIN:  if (status.out_free) state_n = espd_pkg::ST_IDLE;
			default:           state_n = espd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			espd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			espd_pkg::ST_DIV:  cmd.div_step = 1'b1;
			espd_pkg::ST_SPD:  cmd.spd = 1'b1;
			espd_pkg::ST_ERR:  cmd.err = 1'b1;
			espd_pkg::ST_MUL0: cmd.mul0 = 1'b1;
			espd_pkg::ST_MUL1: cmd.mul1 = 1'b1;
			espd_pkg::ST_MUL2: cmd.mul2 = 1'b1;
			espd_pkg::ST_ACC:  cmd.acc = 1'b1;
			espd_pkg::ST_MAG:  cmd.mag = 1'b1;
			espd_pkg::ST_FIN:  cmd.finish = status.out_free;
			default:           cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/espd_dp.sv -----
// ----------------------------------------------------------------------------
// espd_dp
// Datapath: position tracking, bit-serial speed divider, PID state, shared
// multiplier, duty clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module espd_dp #(
	parameter int COUNT_BITS     = 16,
	parameter int GAIN_FRAC_BITS = 8,
	parameter int DUTY_BITS      = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire espd_pkg::cmd_t                        cmd,
	output espd_pkg::status_t                          status,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [espd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [espd_pkg::CFG_W-1:0]            cfg_wdata,
	input  wire logic signed [COUNT_BITS-1:0]          count_now,
	input  wire logic [espd_pkg::MS_W-1:0]             elapsed_ms,
	input  wire logic signed [espd_pkg::SPEED_W-1:0]   target_speed,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [espd_pkg::DUTY_W-1:0]                pwm_duty,
	output logic                                       dir_pin_a,
	output logic                                       dir_pin_b,
	output logic signed [espd_pkg::SPEED_W-1:0]        speed_measured,
	output logic signed [espd_pkg::POS_W-1:0]          position_total
);

	// |delta| * 1000 stays below 2^(COUNT_BITS+9)
	localparam int MW = COUNT_BITS + 10;
	localparam int QW = MW + 1;
	localparam int SW = (QW > espd_pkg::ERR_W) ? QW : espd_pkg::ERR_W;
	localparam int MS_W = espd_pkg::MS_W;
	localparam int ACC_W = espd_pkg::ACC_W;
	localparam int SUM_W = espd_pkg::SUM_W;
	localparam int ERR_W = espd_pkg::ERR_W;
	localparam int DERIV_W = espd_pkg::DERIV_W;
	localparam int DUTY_W = espd_pkg::DUTY_W;
	localparam logic signed [SW-1:0] SPEED_MAX = SW'(33554431);
	localparam logic signed [SW-1:0] SPEED_MIN = -SW'(33554432);
	localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};
	localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'((17'd1 << DUTY_BITS) - 17'd1);

	// configuration
	logic signed [espd_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [DUTY_W-1:0] duty_floor_q, duty_ceiling_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q       <= espd_pkg::GAIN_P_RESET;
			gain_i_q       <= '0;
			gain_d_q       <= '0;
			duty_floor_q   <= '0;
			duty_ceiling_q <= espd_pkg::DUTY_CEILING_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				espd_pkg::REG_GAIN_P:       gain_p_q <= cfg_wdata;
				espd_pkg::REG_GAIN_I:       gain_i_q <= cfg_wdata;
				espd_pkg::REG_GAIN_D:       gain_d_q <= cfg_wdata;
				espd_pkg::REG_DUTY_FLOOR:   duty_floor_q <= cfg_wdata;
				espd_pkg::REG_DUTY_CEILING: duty_ceiling_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// tick state
	logic [COUNT_BITS-1:0] count_prev_q;
	logic signed [espd_pkg::POS_W-1:0] position_q;
	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0] error_prev_q;

	// per-tick working registers
	logic [MS_W-1:0] ms_q;
	logic signed [espd_pkg::SPEED_W-1:0] target_q;
	logic neg_q;
	logic [MW-1:0] quo_q;
	logic [MS_W-1:0] rem_q;
	logic signed [espd_pkg::SPEED_W-1:0] speed_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic signed [espd_pkg::PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] mag_q;

	// load: wrapped delta and |delta| * 1000
	logic [COUNT_BITS-1:0] delta;
	logic [COUNT_BITS-1:0] abs_delta;
	logic [MW-1:0] num;
	assign delta     = COUNT_BITS'(count_now) - count_prev_q;
	assign abs_delta = delta[COUNT_BITS-1] ? COUNT_BITS'(-delta) : delta;
	assign num = (MW'(abs_delta) << 10) - (MW'(abs_delta) << 4) - (MW'(abs_delta) << 3);

	// restoring divide step
	logic [MS_W:0] trial;
	logic          ge;
	assign trial = {rem_q, quo_q[MW-1]};
	assign ge    = trial >= {1'b0, ms_q};

	// signed quotient, saturated
	logic signed [SW-1:0] sq;
	logic signed [espd_pkg::SPEED_W-1:0] speed_sat;
	always_comb begin
		sq = neg_q ? -SW'(quo_q) : SW'(quo_q);
		if (sq > SPEED_MAX) begin
			speed_sat = espd_pkg::SPEED_W'(SPEED_MAX);
		end else if (sq < SPEED_MIN) begin
			speed_sat = espd_pkg::SPEED_W'(SPEED_MIN);
		end else begin
			speed_sat = espd_pkg::SPEED_W'(sq);
		end
	end

	// error, saturating integral, derivative
	logic signed [ERR_W-1:0] err;
	logic signed [SUM_W:0] sum_wide;
	logic signed [SUM_W-1:0] sum_sat;
	assign err      = ERR_W'(target_q) - ERR_W'(speed_q);
	assign sum_wide = (SUM_W+1)'(error_sum_q) + (SUM_W+1)'(err);
	always_comb begin
		if (sum_wide > SUM_MAX) begin
			sum_sat = SUM_W'(SUM_MAX);
		end else if (sum_wide < SUM_MIN) begin
			sum_sat = SUM_W'(SUM_MIN);
		end else begin
			sum_sat = SUM_W'(sum_wide);
		end
	end

	// shared multiplier
	logic signed [espd_pkg::GAIN_W-1:0] mul_a;
	logic signed [espd_pkg::MULB_W-1:0] mul_b;
	always_comb begin
		if (cmd.mul1) begin
			mul_a = gain_i_q;
			mul_b = espd_pkg::MULB_W'(error_sum_q);
		end else if (cmd.mul2) begin
			mul_a = gain_d_q;
			mul_b = espd_pkg::MULB_W'(deriv_q);
		end else begin
			mul_a = gain_p_q;
			mul_b = espd_pkg::MULB_W'(err_q);
		end
	end

	// duty clamp
	logic [ACC_W-1:0] mag_sh;
	logic [DUTY_W-1:0] duty_c, duty;
	assign mag_sh = mag_q >> GAIN_FRAC_BITS;
	always_comb begin
		if (mag_sh < ACC_W'(duty_floor_q)) begin
			duty_c = duty_floor_q;
		end else if (mag_sh > ACC_W'(duty_ceiling_q)) begin
			duty_c = duty_ceiling_q;
		end else begin
			duty_c = DUTY_W'(mag_sh);
		end
		duty = (duty_c > DUTY_MAX) ? DUTY_MAX : duty_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_prev_q <= '0;
			position_q   <= '0;
			error_sum_q  <= '0;
			error_prev_q <= '0;
		end else begin
			if (cmd.load) begin
				count_prev_q <= COUNT_BITS'(count_now);
				position_q   <= position_q + espd_pkg::POS_W'($signed(delta));
			end
			if (cmd.err) begin
				error_sum_q  <= sum_sat;
				error_prev_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ms_q     <= (elapsed_ms == '0) ? MS_W'(1) : elapsed_ms;
			target_q <= target_speed;
			neg_q    <= delta[COUNT_BITS-1];
			quo_q    <= num;
			rem_q    <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? MS_W'(trial - {1'b0, ms_q}) : MS_W'(trial);
			quo_q <= {quo_q[MW-2:0], ge};
		end
		if (cmd.spd) begin
			speed_q <= speed_sat;
		end
		if (cmd.err) begin
			err_q   <= err;
			deriv_q <= DERIV_W'(err) - DERIV_W'(error_prev_q);
		end
		if (cmd.mul0 || cmd.mul1 || cmd.mul2) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.mul0) begin
			acc_q <= '0;
		end else if (cmd.mul1 || cmd.mul2 || cmd.acc) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (cmd.mag) begin
			mag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		end
	end

	// output register
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pwm_duty       <= duty;
			dir_pin_a      <= target_q[espd_pkg::SPEED_W-1];
			dir_pin_b      <= !target_q[espd_pkg::SPEED_W-1];
			speed_measured <= speed_q;
			position_total <= position_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

// ----- src/encoder_speed_pid_drive_unit.sv -----
// ----------------------------------------------------------------------------
// encoder_speed_pid_drive_unit
// Encoder speed measurement and PID motor drive, one transaction per tick.
// ----------------------------------------------------------------------------
// Each result is produced by a sequence of divide, speed, error, multiply,
// accumulate, magnitude and finish states; the speed divider yields one
// quotient bit per cycle. The input stalls while a tick is in work, and the
// output register holds a waiting result meanwhile.
// Reset clears position, previous count, integral and previous error, and
// loads the register reset values.
`default_nettype none

module encoder_speed_pid_drive_unit #(
	parameter int COUNT_BITS     = 16,
	parameter int GAIN_FRAC_BITS = 8,
	parameter int DUTY_BITS      = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [espd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [espd_pkg::CFG_W-1:0]          cfg_wdata,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [COUNT_BITS-1:0]        count_now,
	input  wire logic [espd_pkg::MS_W-1:0]           elapsed_ms,
	input  wire logic signed [espd_pkg::SPEED_W-1:0] target_speed,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [espd_pkg::DUTY_W-1:0]              pwm_duty,
	output logic                                     dir_pin_a,
	output logic                                     dir_pin_b,
	output logic signed [espd_pkg::SPEED_W-1:0]      speed_measured,
	output logic signed [espd_pkg::POS_W-1:0]        position_total
);

	espd_pkg::cmd_t    cmd;
	espd_pkg::status_t status;

	espd_ctrl #(
		.DIV_STEPS(COUNT_BITS + 10)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	espd_dp #(
		.COUNT_BITS     (COUNT_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.DUTY_BITS      (DUTY_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.count_now      (count_now),
		.elapsed_ms     (elapsed_ms),
		.target_speed   (target_speed),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pwm_duty       (pwm_duty),
		.dir_pin_a      (dir_pin_a),
		.dir_pin_b      (dir_pin_b),
		.speed_measured (speed_measured),
		.position_total (position_total)
	);

endmodule

`default_nettype wire
